FILE: rtl/core/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types and constants for the streaming find-and-replace block.
// ----------------------------------------------------------------------------
package sfr_pkg;

	localparam int BYTE_W              = 8;
	localparam int WORD_W              = 64;
	localparam int LEN_W               = 4;
	localparam int CFG_IDX_W           = 2;
	localparam int BUNDLE_N            = 8;
	localparam int DEF_MAX_PATTERN     = 8;
	localparam int DEF_MAX_REPLACEMENT = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_PATTERN_BYTES      = 2'd0,
		CFG_PATTERN_LENGTH     = 2'd1,
		CFG_REPLACEMENT_BYTES  = 2'd2,
		CFG_REPLACEMENT_LENGTH = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [WORD_W-1:0] pattern_bytes;
		logic [LEN_W-1:0]  pattern_length;
		logic [WORD_W-1:0] replacement_bytes;
		logic [LEN_W-1:0]  replacement_length;
	} cfg_t;

	// Result items produced by one input byte, oldest in entry 0.
	typedef struct packed {
		logic [BUNDLE_N-1:0][BYTE_W-1:0] data;
		logic [LEN_W-1:0]                count;
		logic                            last;
		logic                            bare;
	} bundle_t;

endpackage

FILE: rtl/core/sfr_stream_if.sv
// ----------------------------------------------------------------------------
// sfr_stream_if
// Valid/ready channels for the text input and the rewritten text output.
// ----------------------------------------------------------------------------
interface sfr_in_if import sfr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] char_in;
	logic              end_of_text;

	modport source (output valid, char_in, end_of_text, input ready);
	modport sink   (input valid, char_in, end_of_text, output ready);
endinterface

interface sfr_out_if import sfr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] char_out;
	logic              char_valid;
	logic              last_out;

	modport source (output valid, char_out, char_valid, last_out, input ready);
	modport sink   (input valid, char_out, char_valid, last_out, output ready);
endinterface

FILE: rtl/core/sfr_match.sv
// ----------------------------------------------------------------------------
// sfr_match
// Pending-byte window, pattern compare and per-byte result bundle.
// ----------------------------------------------------------------------------
module sfr_match import sfr_pkg::*; #(
	parameter int MAX_PATTERN     = DEF_MAX_PATTERN,
	parameter int MAX_REPLACEMENT = DEF_MAX_REPLACEMENT
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cfg_t              cfg,
	input  logic              clear,
	input  logic              xfer,
	input  logic [BYTE_W-1:0] char_in,
	input  logic              end_of_text,
	output bundle_t           bundle,
	output logic [LEN_W-1:0]  win_cnt
);

	logic [BYTE_W-1:0] win_q [MAX_PATTERN];
	logic [BYTE_W-1:0] cand  [MAX_PATTERN];
	logic [BYTE_W-1:0] win_d [MAX_PATTERN];
	logic [LEN_W-1:0]  cnt_q, cnt_d;
	logic [LEN_W-1:0]  plen, rlen;
	logic              full, hit;

	// effective lengths: pattern 1..MAX_PATTERN, replacement 0..MAX_REPLACEMENT
	always_comb begin
		if (cfg.pattern_length == '0) begin
			plen = LEN_W'(1);
		end else if (cfg.pattern_length > LEN_W'(MAX_PATTERN)) begin
			plen = LEN_W'(MAX_PATTERN);
		end else begin
			plen = cfg.pattern_length;
		end
		if (cfg.replacement_length > LEN_W'(MAX_REPLACEMENT)) begin
			rlen = LEN_W'(MAX_REPLACEMENT);
		end else begin
			rlen = cfg.replacement_length;
		end
	end

	// window with the new byte appended, then compare
	always_comb begin
		hit = 1'b1;
		for (int i = 0; i < MAX_PATTERN; i++) begin
			cand[i] = (LEN_W'(i) == cnt_q) ? char_in : win_q[i];
			if (LEN_W'(i) < plen && cand[i] != cfg.pattern_bytes[i*BYTE_W +: BYTE_W]) begin
				hit = 1'b0;
			end
		end
		for (int i = 0; i < MAX_PATTERN; i++) begin
			if (i + 1 < MAX_PATTERN) begin
				win_d[i] = cand[i+1];
			end else begin
				win_d[i] = cand[i];
			end
		end
		full = ((cnt_q + LEN_W'(1)) == plen);
	end

	always_comb begin
		bundle = '0;
		bundle.last = end_of_text;
		if (full && hit) begin
			for (int i = 0; i < BUNDLE_N; i++) begin
				bundle.data[i] = cfg.replacement_bytes[i*BYTE_W +: BYTE_W];
			end
			bundle.count = rlen;
		end else if (end_of_text) begin
			// flush everything pending, oldest first
			for (int i = 0; i < MAX_PATTERN; i++) begin
				bundle.data[i] = cand[i];
			end
			bundle.count = cnt_q + LEN_W'(1);
		end else if (full) begin
			bundle.data[0] = cand[0];
			bundle.count   = LEN_W'(1);
		end
		// end of text with nothing to emit: one bare end mark
		if (end_of_text && bundle.count == '0) begin
			bundle.data  = '0;
			bundle.count = LEN_W'(1);
			bundle.bare  = 1'b1;
		end

		if (end_of_text || (full && hit)) begin
			cnt_d = '0;
		end else if (full) begin
			cnt_d = plen - LEN_W'(1);
		end else begin
			cnt_d = cnt_q + LEN_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			for (int i = 0; i < MAX_PATTERN; i++) begin
				win_q[i] <= '0;
			end
		end else if (clear) begin
			cnt_q <= '0;
		end else if (xfer) begin
			cnt_q <= cnt_d;
			if (full) begin
				win_q <= win_d;
			end else begin
				win_q <= cand;
			end
		end
	end

	assign win_cnt = cnt_q;

endmodule

FILE: rtl/core/sfr_serializer.sv
// ----------------------------------------------------------------------------
// sfr_serializer
// Holds one result bundle and hands its items to an output register.
// ----------------------------------------------------------------------------
module sfr_serializer import sfr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      load,
	input  bundle_t   bundle,
	output logic      ready,
	sfr_out_if.source text_out
);

	logic [BUNDLE_N-1:0][BYTE_W-1:0] data_q;
	logic [LEN_W-1:0]                rem_q;
	logic                            last_q;
	logic                            bare_q;
	logic                            ovld_q;
	logic [BYTE_W-1:0]               ochar_q;
	logic                            ocv_q;
	logic                            olast_q;
	logic                            pop;

	assign pop   = (rem_q != '0) && (!ovld_q || text_out.ready);
	assign ready = (rem_q == '0) || ((rem_q == LEN_W'(1)) && pop);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			ovld_q <= 1'b0;
		end else begin
			if (load) begin
				rem_q <= bundle.count;
			end else if (pop) begin
				rem_q <= rem_q - LEN_W'(1);
			end
			if (pop) begin
				ovld_q <= 1'b1;
			end else if (text_out.ready) begin
				ovld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			data_q <= bundle.data;
			last_q <= bundle.last;
			bare_q <= bundle.bare;
		end else if (pop) begin
			data_q <= data_q >> BYTE_W;
		end
		if (pop) begin
			ochar_q <= data_q[0];
			ocv_q   <= !bare_q;
			olast_q <= last_q && (rem_q == LEN_W'(1));
		end
	end

	assign text_out.valid      = ovld_q;
	assign text_out.char_out   = ochar_q;
	assign text_out.char_valid = ocv_q;
	assign text_out.last_out   = olast_q;

endmodule

FILE: rtl/core/stream_find_and_replace.sv
// ----------------------------------------------------------------------------
// stream_find_and_replace
// Replaces each leftmost, non-overlapping pattern match in a byte stream.
// ----------------------------------------------------------------------------
//  channel   direction  payload                              transfer when
//  text_in   sink       char_in, end_of_text                 valid & ready
//  text_out  source     char_out, char_valid, last_out       valid & ready
//  cfg       write      cfg_index, cfg_data                  cfg_we
//
//  Each input byte is compared and turned into a bundle of 0..8 results in
//  the cycle it is taken; the bundle register then drains one item per
//  cycle into the output register unless the output stalls. Throughput is
//  one byte per cycle if each byte yields at most one item and the output
//  does not stall; a larger bundle holds the input off until its last item
//  is popped. Reset (arst_n low) empties the window and both registers.
// ----------------------------------------------------------------------------
module stream_find_and_replace import sfr_pkg::*; #(
	parameter int MAX_PATTERN     = DEF_MAX_PATTERN,
	parameter int MAX_REPLACEMENT = DEF_MAX_REPLACEMENT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [WORD_W-1:0]    cfg_data,
	sfr_in_if.sink               text_in,
	sfr_out_if.source            text_out
);

	cfg_t             cfg_q;
	bundle_t          bundle;
	logic             in_xfer;
	logic             ser_ready;
	logic             clear;
	logic [LEN_W-1:0] win_cnt;

	// configuration registers; a new pattern length drops pending bytes
	assign clear = cfg_we && (cfg_reg_t'(cfg_index) == CFG_PATTERN_LENGTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pattern_bytes      <= '0;
			cfg_q.pattern_length     <= LEN_W'(1);
			cfg_q.replacement_bytes  <= '0;
			cfg_q.replacement_length <= '0;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_PATTERN_BYTES: begin
					cfg_q.pattern_bytes <= cfg_data;
				end
				CFG_PATTERN_LENGTH: begin
					cfg_q.pattern_length <= cfg_data[LEN_W-1:0];
				end
				CFG_REPLACEMENT_BYTES: begin
					cfg_q.replacement_bytes <= cfg_data;
				end
				CFG_REPLACEMENT_LENGTH: begin
					cfg_q.replacement_length <= cfg_data[LEN_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	// input is taken whenever the bundle register frees up this cycle
	assign text_in.ready = ser_ready;
	assign in_xfer       = text_in.valid && ser_ready;

	sfr_match #(
		.MAX_PATTERN     (MAX_PATTERN),
		.MAX_REPLACEMENT (MAX_REPLACEMENT)
	) u_match (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg_q),
		.clear       (clear),
		.xfer        (in_xfer),
		.char_in     (text_in.char_in),
		.end_of_text (text_in.end_of_text),
		.bundle      (bundle),
		.win_cnt     (win_cnt)
	);

	sfr_serializer u_ser (
		.clk      (clk),
		.arst_n   (arst_n),
		.load     (in_xfer),
		.bundle   (bundle),
		.ready    (ser_ready),
		.text_out (text_out)
	);

	// a bare item exists only as the end mark of a text
	a_bare_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		text_out.valid && !text_out.char_valid |-> text_out.last_out)
		else $error("bare output item without last mark");

	// the last byte of a text leaves the window empty
	a_eot_flush: assert property (@(posedge clk) disable iff (!arst_n)
		in_xfer && text_in.end_of_text |=> win_cnt == '0)
		else $error("window not flushed at end of text");

	// pending bytes never fill the window
	a_win_bound: assert property (@(posedge clk) disable iff (!arst_n)
		win_cnt < LEN_W'(MAX_PATTERN))
		else $error("window count out of range");

endmodule

FILE: test/stream_find_and_replace_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_find_and_replace_tb
// Self-checking bench for the streaming find-and-replace block. A short
// scripted run covers the reset settings, full-length patterns, saturated
// lengths and the bare end mark. Randomized phases then follow, each with
// its own register setting and a text built mostly from pattern hits and
// broken prefixes. Every result transfer is checked against an in-bench
// model of the window under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module stream_find_and_replace_tb;
	import sfr_pkg::*;

	localparam int PERIOD         = 4;
	localparam int SETTLE_CYCLES  = 4;    // margin before a register write
	localparam int DRAIN_CYCLES   = 8;    // quiet time at the end to catch stray results
	localparam int HOLDOFF_CYCLES = 200;  // long sink stall, fills the block
	localparam int STALL_LIMIT    = 2000; // cycles with no transfer before giving up
	localparam int NUM_PHASES     = 8;
	localparam int PHASE_ITEMS    = 15;

	// One byte of rewritten text as seen on the output channel.
	typedef struct packed {
		logic [BYTE_W-1:0] char_out;
		logic              char_valid;
		logic              last_out;
	} text_item_t;

	typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

	// A scripted step: either a register write or one text byte. Byte rows
	// with a typed result produce exactly one item, which is checked as typed.
	typedef struct packed {
		row_kind_t         kind;
		cfg_reg_t          idx;
		logic [WORD_W-1:0] val;
		logic [BYTE_W-1:0] ch;
		logic              eot;
		logic              typed;
		text_item_t        want;
	} stim_row_t;

	localparam int SCRIPT_LEN = 34;
	localparam stim_row_t SCRIPT [SCRIPT_LEN] = '{
		// reset settings: pattern is a single zero byte, replacement is empty
		'{ROW_BYTE, CFG_PATTERN_BYTES, 64'h0, 8'h00, 1'b1, 1'b1, '{8'h00, 1'b0, 1'b1}},
		'{ROW_BYTE, CFG_PATTERN_BYTES, 64'h0, 8'hFF, 1'b0, 1'b1, '{8'hFF, 1'b1, 1'b0}},
		'{ROW_BYTE, CFG_PATTERN_BYTES, 64'h0, 8'h00, 1'b0, 1'b0, '0},
		'{ROW_BYTE, CFG_PATTERN_BYTES, 64'h0, 8'h80, 1'b1, 1'b1, '{8'h80, 1'b1, 1'b1}},
		// two-byte pattern {00, FF}; replacement length 15 saturates to 8
		'{ROW_CFG, CFG_PATTERN_BYTES, 64'h0000_0000_0000_FF00, 8'h00, 1'b0, 1'b0, '0},
		'{ROW_CFG, CFG_PATTERN_LENGTH, 64'd2, 8'h00, 1'b0, 1'b0, '0},
		'{ROW_CFG, CFG_REPLACEMENT_BYTES, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 1'b0, 1'b0, '0},
		'{ROW_CFG, CFG_REPLACEMENT_LENGTH, 64'd15, 8'h00, 1'b0, 1'b0, '0},
		'{ROW_BYTE, CFG_PATTERN_BYTES, 64'h0, 8'h00, 1'b0, 1'b0, '0},
		'{ROW_BYTE, CFG_PATTERN_BYTES, 64'h0, 8'hFF, 1'b0, 1'b0, '0},
		'{ROW_BYTE, CFG_PATTERN_BYTES, 64'h0, 8'h00, 1'b0, 1'b0, '0},
		'{ROW_BYTE, CFG_PATTERN_BYTES, 64'h0, 8'h00, 1'b0, 1'b0, '0},
		'{ROW_BYTE, CFG_PATTERN_BYTES, 64'h0, 8'hFF, 1'b0, 1'b0, '0},
		'{ROW_BYTE, CFG_PATTERN_BYTES, 64'h0, 8'h7F, 1'b1, 1'b0, '0},
		// zero pattern length acts as one; empty replacement gives a bare end mark
		'{ROW_CFG, CFG_PATTERN_BYTES, 64'h0000_0000_0000_0055, 8'h00, 1'b0, 1'b0, '0},
		'{ROW_CFG, CFG_PATTERN_LENGTH, 64'd0, 8'h00, 1'b0, 1'b0, '0},
		'{ROW_CFG, CFG_REPLACEMENT_LENGTH, 64'd0, 8'h00, 1'b0, 1'b0, '0},
		'{ROW_BYTE, CFG_PATTERN_BYTES, 64'h0, 8'h55, 1'b1, 1'b0, '0},
		'{ROW_BYTE, CFG_PATTERN_BYTES, 64'h0, 8'hAA, 1'b1, 1'b0, '0},
		// full eight-byte pattern replaced by one zero byte, then a flushed tail
		'{ROW_CFG, CFG_PATTERN_BYTES, 64'h0123_4567_89AB_CDEF, 8'h00, 1'b0, 1'b0, '0},
		'{ROW_CFG, CFG_PATTERN_LENGTH, 64'd8, 8'h00, 1'b0, 1'b0, '0},
		'{ROW_CFG, CFG_REPLACEMENT_BYTES, 64'hA5A5_A5A5_A5A5_A500, 8'h00, 1'b0, 1'b0, '0},
		'{ROW_CFG, CFG_REPLACEMENT_LENGTH, 64'd1, 8'h00, 1'b0, 1'b0, '0},
		'{ROW_BYTE, CFG_PATTERN_BYTES, 64'h0, 8'hEF, 1'b0, 1'b0, '0},
		'{ROW_BYTE, CFG_PATTERN_BYTES, 64'h0, 8'hCD, 1'b0, 1'b0, '0},
		'{ROW_BYTE, CFG_PATTERN_BYTES, 64'h0, 8'hAB, 1'b0, 1'b0, '0},
		'{ROW_BYTE, CFG_PATTERN_BYTES, 64'h0, 8'h89, 1'b0, 1'b0, '0},
		'{ROW_BYTE, CFG_PATTERN_BYTES, 64'h0, 8'h67, 1'b0, 1'b0, '0},
		'{ROW_BYTE, CFG_PATTERN_BYTES, 64'h0, 8'h45, 1'b0, 1'b0, '0},
		'{ROW_BYTE, CFG_PATTERN_BYTES, 64'h0, 8'h23, 1'b0, 1'b0, '0},
		'{ROW_BYTE, CFG_PATTERN_BYTES, 64'h0, 8'h01, 1'b0, 1'b0, '0},
		'{ROW_BYTE, CFG_PATTERN_BYTES, 64'h0, 8'hEF, 1'b0, 1'b0, '0},
		'{ROW_BYTE, CFG_PATTERN_BYTES, 64'h0, 8'hCD, 1'b0, 1'b0, '0},
		'{ROW_BYTE, CFG_PATTERN_BYTES, 64'h0, 8'hAB, 1'b1, 1'b0, '0}
	};

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [WORD_W-1:0]    cfg_data;

	sfr_in_if  text_in_ch ();
	sfr_out_if text_out_ch ();

	stream_find_and_replace dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.text_in   (text_in_ch),
		.text_out  (text_out_ch)
	);

	always #(PERIOD / 2) clk = ~clk;

	// Model of the block: register copies (reset values) and the match window.
	logic [WORD_W-1:0] pat_word    = '0;
	logic [LEN_W-1:0]  pat_len_reg = 4'd1;
	logic [WORD_W-1:0] rep_word    = '0;
	logic [LEN_W-1:0]  rep_len_reg = 4'd0;
	logic [BYTE_W-1:0] win_bytes [DEF_MAX_PATTERN];
	int                win_fill    = 0;

	text_item_t burst_items [$];   // items caused by the byte just taken
	text_item_t expected_text [$]; // items still owed by the block, oldest first

	int   fail_count  = 0;
	logic tx_idle_en  = 1'b1;
	logic rx_idle_en  = 1'b1;
	logic holdoff_req = 1'b0;

	// Length zero counts as one; anything above the window depth saturates.
	function automatic int eff_pat_len();
		if (pat_len_reg == 0)
			return 1;
		if (pat_len_reg > DEF_MAX_PATTERN)
			return DEF_MAX_PATTERN;
		return pat_len_reg;
	endfunction

	function automatic void apply_reg(input cfg_reg_t idx, input logic [WORD_W-1:0] val);
		case (idx)
			CFG_PATTERN_BYTES: pat_word = val;
			CFG_PATTERN_LENGTH: begin
				// pending window bytes are dropped on a length change
				pat_len_reg = val[LEN_W-1:0];
				win_fill    = 0;
			end
			CFG_REPLACEMENT_BYTES: rep_word = val;
			CFG_REPLACEMENT_LENGTH: rep_len_reg = val[LEN_W-1:0];
			default: ;
		endcase
	endfunction

	// Push one byte through the window and collect what it releases.
	function automatic void rewrite_byte(input logic [BYTE_W-1:0] ch, input logic eot);
		int   plen;
		int   rlen;
		int   i;
		logic hit;
		plen = eff_pat_len();
		rlen = (rep_len_reg > DEF_MAX_REPLACEMENT) ? DEF_MAX_REPLACEMENT : rep_len_reg;
		burst_items = {};
		if (win_fill >= plen)
			win_fill = 0;
		win_bytes[win_fill] = ch;
		win_fill++;
		if (win_fill >= plen) begin
			hit = 1'b1;
			for (i = 0; i < plen; i++)
				if (win_bytes[i] != pat_word[i*BYTE_W +: BYTE_W])
					hit = 1'b0;
			if (hit) begin
				for (i = 0; i < rlen; i++)
					burst_items.push_back(text_item_t'{rep_word[i*BYTE_W +: BYTE_W], 1'b1, 1'b0});
				win_fill = 0;
			end else begin
				// no hit: release the oldest byte and slide by one
				burst_items.push_back(text_item_t'{win_bytes[0], 1'b1, 1'b0});
				for (i = 1; i < win_fill; i++)
					win_bytes[i-1] = win_bytes[i];
				win_fill--;
			end
		end
		if (eot) begin
			for (i = 0; i < win_fill; i++)
				burst_items.push_back(text_item_t'{win_bytes[i], 1'b1, 1'b0});
			win_fill = 0;
			// nothing left to carry the end: send a bare end mark
			if (burst_items.size() == 0)
				burst_items.push_back(text_item_t'{8'h00, 1'b0, 1'b0});
			burst_items[burst_items.size()-1].last_out = 1'b1;
		end
	endfunction

	// Offer one byte, optionally after random gaps, and book its results once
	// the transfer happens. valid stays high afterwards for back-to-back bytes.
	task automatic send_text_byte(input logic [BYTE_W-1:0] ch, input logic eot,
			input logic typed, input text_item_t want);
		int i;
		while (tx_idle_en && $urandom_range(99) < 8) begin
			text_in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		text_in_ch.valid       <= 1'b1;
		text_in_ch.char_in     <= ch;
		text_in_ch.end_of_text <= eot;
		do @(posedge clk); while (!text_in_ch.ready);
		rewrite_byte(ch, eot);
		if (typed)
			expected_text.push_back(want);
		else
			for (i = 0; i < burst_items.size(); i++)
				expected_text.push_back(burst_items[i]);
	endtask

	// Drop valid and wait until the block has gone quiet. Bytes that release
	// nothing may still be in the pipe, hence the extra cycles.
	task automatic settle();
		text_in_ch.valid <= 1'b0;
		do @(posedge clk); while (expected_text.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Leaves cfg_we high so writes can run back to back; the caller lowers it.
	task automatic write_reg(input cfg_reg_t idx, input logic [WORD_W-1:0] val);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(posedge clk);
		apply_reg(idx, val);
	endtask

	// Sink side: random stalls, or one long hold-off counted here.
	initial begin
		text_out_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (holdoff_req) begin
				text_out_ch.ready <= 1'b0;
				repeat (HOLDOFF_CYCLES) @(posedge clk);
				holdoff_req = 1'b0;
			end
			text_out_ch.ready <= !(rx_idle_en && $urandom_range(99) < 8);
		end
	end

	// Result checker: each output transfer against the oldest expectation.
	always @(posedge clk) begin : result_check
		text_item_t want;
		if (arst_n && text_out_ch.valid && text_out_ch.ready) begin
			if (expected_text.size() == 0) begin
				$error("unexpected transfer: char_out %h char_valid %b last_out %b",
					text_out_ch.char_out, text_out_ch.char_valid, text_out_ch.last_out);
				fail_count++;
			end else begin
				want = expected_text.pop_front();
				if (text_out_ch.char_out !== want.char_out) begin
					$error("char_out: expected %h, got %h", want.char_out, text_out_ch.char_out);
					fail_count++;
				end
				if (text_out_ch.char_valid !== want.char_valid) begin
					$error("char_valid: expected %b, got %b", want.char_valid,
						text_out_ch.char_valid);
					fail_count++;
				end
				if (text_out_ch.last_out !== want.last_out) begin
					$error("last_out: expected %b, got %b", want.last_out, text_out_ch.last_out);
					fail_count++;
				end
			end
		end
	end

	// Watchdog: too long without any transfer on either channel ends the run.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < STALL_LIMIT) begin
			@(posedge clk);
			if ((text_in_ch.valid && text_in_ch.ready) || (text_out_ch.valid && text_out_ch.ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Some tests failed");
		$finish;
	end

	initial begin : stimulus
		int                r;
		int                ph;
		int                n;
		int                i;
		int                k;
		int                len;
		int                plen;
		logic              paused;
		logic [BYTE_W-1:0] alpha [3];
		logic [WORD_W-1:0] word;
		logic [BYTE_W-1:0] chunk [$];

		text_in_ch.valid       <= 1'b0;
		text_in_ch.char_in     <= '0;
		text_in_ch.end_of_text <= 1'b0;
		cfg_we                 <= 1'b0;
		cfg_index              <= CFG_PATTERN_BYTES;
		cfg_data               <= '0;
		arst_n                 <= 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Scripted part. A group of register rows is preceded by a settle.
		for (r = 0; r < SCRIPT_LEN; r++) begin
			if (SCRIPT[r].kind == ROW_CFG) begin
				if (r == 0 || SCRIPT[r-1].kind != ROW_CFG)
					settle();
				write_reg(SCRIPT[r].idx, SCRIPT[r].val);
			end else begin
				if (r > 0 && SCRIPT[r-1].kind == ROW_CFG)
					cfg_we <= 1'b0;
				send_text_byte(SCRIPT[r].ch, SCRIPT[r].eot, SCRIPT[r].typed, SCRIPT[r].want);
			end
		end

		// Random phases. Phase 4 runs with no gaps on either side, phase 5 holds
		// the sink off while bytes keep coming, phase 6 pauses the source until
		// the block drains. Phases 1, 4 and 7 stop mid-text, so the next length
		// write has pending window bytes to discard.
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			settle();
			tx_idle_en = (ph != 4);
			rx_idle_en = (ph != 4);

			// small alphabet so that hits and near misses are common
			for (k = 0; k < 3; k++)
				alpha[k] = BYTE_W'($urandom);
			for (k = 0; k < DEF_MAX_PATTERN; k++)
				word[k*BYTE_W +: BYTE_W] = alpha[$urandom_range(2)];
			if (ph == 0 || $urandom_range(3) != 0)
				write_reg(CFG_PATTERN_BYTES, word);
			case (ph)
				1: len = 15;
				2: len = 8;
				3: len = 1;
				6: len = 0;
				default: len = $urandom_range(1, 8);
			endcase
			if (ph < 4 || ph == 6 || $urandom_range(3) != 0)
				write_reg(CFG_PATTERN_LENGTH, WORD_W'(len));
			if (ph == 0 || $urandom_range(3) != 0)
				write_reg(CFG_REPLACEMENT_BYTES, {$urandom, $urandom});
			case (ph)
				1: len = 0;
				2: len = 8;
				3: len = 15;
				default: len = $urandom_range(0, 8);
			endcase
			if (ph < 4 || $urandom_range(3) != 0)
				write_reg(CFG_REPLACEMENT_LENGTH, WORD_W'(len));
			cfg_we <= 1'b0;

			if (ph == 5)
				holdoff_req = 1'b1;

			n      = 0;
			paused = 1'b0;
			while (n < PHASE_ITEMS) begin
				plen  = eff_pat_len();
				chunk = {};
				k     = $urandom_range(99);
				if (k < 60) begin
					// a full pattern occurrence
					for (i = 0; i < plen; i++)
						chunk.push_back(pat_word[i*BYTE_W +: BYTE_W]);
				end else if (k < 75) begin
					// a broken prefix
					len = $urandom_range(plen - 1);
					for (i = 0; i < len; i++)
						chunk.push_back(pat_word[i*BYTE_W +: BYTE_W]);
					chunk.push_back(alpha[$urandom_range(2)]);
				end else if (k < 88) begin
					chunk.push_back(alpha[$urandom_range(2)]);
				end else begin
					chunk.push_back(BYTE_W'($urandom));
				end
				for (i = 0; i < chunk.size(); i++) begin
					send_text_byte(chunk[i], $urandom_range(99) < 8, 1'b0, '0);
					n++;
				end
				if (ph == 6 && !paused && n >= PHASE_ITEMS / 2) begin
					paused = 1'b1;
					text_in_ch.valid <= 1'b0;
					do @(posedge clk); while (expected_text.size() != 0);
				end
			end
			if (ph % 3 != 1)
				send_text_byte(BYTE_W'($urandom), 1'b1, 1'b0, '0);
		end

		text_in_ch.valid <= 1'b0;
		do @(posedge clk); while (expected_text.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule

FILE: sim.f
rtl/core/sfr_pkg.sv
rtl/core/sfr_stream_if.sv
rtl/core/sfr_match.sv
rtl/core/sfr_serializer.sv
rtl/core/stream_find_and_replace.sv
test/stream_find_and_replace_tb.sv
